// File: design/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants of the path player
// Node row layout, operation codes, controller states and arithmetic widths.
// ----------------------------------------------------------------------------
package crp_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_RESTART = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic {
        CFG_NODE_COUNT = 1'b0,
        CFG_PLAY_SPEED = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DUR,
        S_ADV,
        S_READ,
        S_DIV_GO,
        S_DIV_WAIT,
        S_T2_GO,
        S_T2_WAIT,
        S_T3_GO,
        S_T3_WAIT,
        S_HERM,
        S_CH_GO,
        S_CH_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_w;
        logic        [31:0] dur;
    } t_node;

    typedef struct packed {
        logic start;
        logic clear;
    } t_mul_cmd;

    localparam int NODE_W  = $bits(t_node);
    localparam int ACC_W   = 80;  // accumulator of the channel sums
    localparam int MB_W    = 34;  // serial multiplier operand, signed
    localparam int H_W     = 43;  // Hermite weights, signed
    localparam int T_W     = 24;
    localparam int T2_W    = 32;
    localparam int T3_W    = 40;
    localparam int NUM_W   = 48;
    localparam int DEN_W   = 32;
    localparam int OUT_SHIFT = 17;

endpackage

// File: design/crp_ram.sv
// ----------------------------------------------------------------------------
// crp_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/crp_div.sv
// ----------------------------------------------------------------------------
// crp_div: restoring divider, one quotient bit per cycle
// Divides a 48-bit dividend by a nonzero 32-bit divisor.
// ----------------------------------------------------------------------------
module crp_div
    import crp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem, r_num[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// File: design/crp_mul.sv
// ----------------------------------------------------------------------------
// crp_mul: bit-serial signed multiply-accumulate
// Takes one multiplier bit per cycle, least significant first, and adds the
// shifted multiplicand into an accumulator that can be kept across products.
// ----------------------------------------------------------------------------
module crp_mul
    import crp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mul_cmd                i_cmd,
    input  logic signed [ACC_W-1:0] i_m,
    input  logic signed [MB_W-1:0]  i_b,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_done
);

    localparam int CNT_W = $clog2(MB_W);

    logic signed [ACC_W-1:0] r_m;
    logic        [MB_W-1:0]  r_b;
    logic signed [ACC_W-1:0] r_acc;
    logic        [CNT_W-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic                    last;
    logic signed [ACC_W-1:0] addend;

    assign last = r_cnt == CNT_W'(MB_W - 1);

    // The top bit of the multiplier carries negative weight.
    always_comb begin
        if (!r_b[0]) begin
            addend = '0;
        end else if (last) begin
            addend = -r_m;
        end else begin
            addend = r_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_m <= i_m;
            r_b <= i_b;
            if (i_cmd.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            r_acc <= r_acc + addend;
            r_m   <= r_m <<< 1;
            r_b   <= {1'b0, r_b[MB_W-1:1]};
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// File: design/catmull_rom_path_player.sv
// ----------------------------------------------------------------------------
// catmull_rom_path_player: keyframe path player with Catmull-Rom interpolation
// Stores path nodes, advances through segments on time ticks and gives the
// interpolated position and quaternion, or the finished result at playback
// end, for each tick while playing.
// A write or restart item is done once accepted. For a tick item while
// playing, a serial divider forms the segment parameter (skipped when the
// segment duration is zero), and one bit-serial multiplier forms t squared,
// t cubed and the 28 weighted node products of the seven channels. A tick
// that ends playback gives an all-zero pose with the finished flag, and a
// tick while stopped gives no result. Items are taken one at a time; a
// finished result waits in the output register while the next item is
// accepted. Node slots must be written before playback reads them.
// ----------------------------------------------------------------------------
module catmull_rom_path_player
    import crp_pkg::*;
#(
    parameter int MAX_NODES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_node_index,
    input  logic signed [31:0] i_node_pos_x,
    input  logic signed [31:0] i_node_pos_y,
    input  logic signed [31:0] i_node_pos_z,
    input  logic signed [15:0] i_node_rot_x,
    input  logic signed [15:0] i_node_rot_y,
    input  logic signed [15:0] i_node_rot_z,
    input  logic signed [15:0] i_node_rot_w,
    input  logic [31:0]        i_node_duration,
    input  logic [31:0]        i_elapsed,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [15:0] o_rot_x,
    output logic signed [15:0] o_rot_y,
    output logic signed [15:0] o_rot_z,
    output logic signed [15:0] o_rot_w,
    output logic               o_finished,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int IW = (AW > 8) ? AW : 8;

    t_state                  r_state, n_state;
    logic [8:0]              r_node_count;
    logic [15:0]             r_play_speed;
    logic [CW-1:0]           r_seg;
    logic [31:0]             r_time;
    logic                    r_started;
    logic                    r_playing;
    logic [31:0]             r_elapsed;
    logic [47:0]             r_thresh;
    logic [2:0]              r_rdk;
    t_node                   r_row [4];
    logic [T_W-1:0]          r_t;
    logic [T2_W-1:0]         r_t2;
    logic [T3_W-1:0]         r_t3;
    logic signed [H_W-1:0]   r_h [4];
    logic [2:0]              r_ch;
    logic [1:0]              r_j;
    logic signed [31:0]      r_res_pos [3];
    logic signed [15:0]      r_res_rot [4];
    logic                    r_res_fin;
    logic                    r_out_valid;

    logic                    accept;
    logic                    cfg_we;
    logic [CW-1:0]           cnt;
    logic [CW-1:0]           last_seg;
    logic [CW-1:0]           seg_p1;
    logic [CW-1:0]           seg_ip;
    logic [CW-1:0]           seg_i2;
    logic [CW-1:0]           rd_seg;
    logic                    adv;
    logic [IW-1:0]           widx;
    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;
    logic [NODE_W-1:0]       ram_rdata;
    t_node                   wr_node;
    t_node                   rd_node;
    logic                    div_start;
    logic [NUM_W-1:0]        div_quo;
    logic                    div_done;
    t_mul_cmd                mul_cmd;
    logic signed [ACC_W-1:0] mul_m;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [ACC_W-1:0] mul_acc;
    logic                    mul_done;
    logic signed [MB_W-1:0]  yp, y0, y1, y2;
    logic                    out_free;
    logic                    load_out;

    function automatic logic signed [MB_W-1:0] chan_val(t_node n, logic [2:0] ch);
        logic signed [MB_W-1:0] v;
        unique case (ch)
            3'd0:    v = MB_W'(n.pos_x);
            3'd1:    v = MB_W'(n.pos_y);
            3'd2:    v = MB_W'(n.pos_z);
            3'd3:    v = MB_W'(n.rot_x);
            3'd4:    v = MB_W'(n.rot_y);
            3'd5:    v = MB_W'(n.rot_z);
            default: v = MB_W'(n.rot_w);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat_pos(logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] sh;
        logic [31:0]             r;
        sh = s >>> OUT_SHIFT;
        if ((&sh[ACC_W-1:31]) || !(|sh[ACC_W-1:31])) begin
            r = sh[31:0];
        end else begin
            r = sh[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_rot(logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] sh;
        logic [15:0]             r;
        sh = s >>> OUT_SHIFT;
        if ((&sh[ACC_W-1:15]) || !(|sh[ACC_W-1:15])) begin
            r = sh[15:0];
        end else begin
            r = sh[ACC_W-1] ? 16'h8000 : 16'h7FFF;
        end
        return r;
    endfunction

    // Node count clamped to the range the store can hold.
    always_comb begin
        if (CW'(r_node_count) < CW'(2)) begin
            cnt = CW'(2);
        end else if (CW'(r_node_count) > CW'(MAX_NODES)) begin
            cnt = CW'(MAX_NODES);
        end else begin
            cnt = CW'(r_node_count);
        end
        last_seg = cnt - CW'(2);
        seg_p1   = r_seg + 1'b1;
        seg_ip   = (r_seg == '0) ? '0 : r_seg - 1'b1;
        seg_i2   = (r_seg + CW'(2) >= cnt) ? cnt - 1'b1 : r_seg + CW'(2);
    end

    assign accept      = i_valid && o_ready;
    assign cfg_we      = i_cfg_valid;
    assign o_cfg_ready = 1'b1;
    assign o_ready     = r_state == S_IDLE;
    assign widx        = IW'(i_node_index);
    assign rd_node     = t_node'(ram_rdata);
    assign adv         = {8'd0, r_time, 8'd0} >= r_thresh;
    assign out_free    = !r_out_valid || i_ready;

    assign wr_node.pos_x = i_node_pos_x;
    assign wr_node.pos_y = i_node_pos_y;
    assign wr_node.pos_z = i_node_pos_z;
    assign wr_node.rot_x = i_node_rot_x;
    assign wr_node.rot_y = i_node_rot_y;
    assign wr_node.rot_z = i_node_rot_z;
    assign wr_node.rot_w = i_node_rot_w;
    assign wr_node.dur   = i_node_duration;

    // One bit wider than the index so that a full power-of-two store compares.
    assign ram_we = accept && t_op'(i_operation) == OP_WRITE
                    && (IW+1)'(widx) < (IW+1)'(MAX_NODES);

    always_comb begin
        unique case (r_rdk)
            3'd0:    rd_seg = seg_ip;
            3'd1:    rd_seg = r_seg;
            3'd2:    rd_seg = seg_p1;
            default: rd_seg = seg_i2;
        endcase
        ram_raddr = (r_state == S_READ) ? rd_seg[AW-1:0] : r_seg[AW-1:0];
    end

    assign yp = chan_val(r_row[0], r_ch);
    assign y0 = chan_val(r_row[1], r_ch);
    assign y1 = chan_val(r_row[2], r_ch);
    assign y2 = chan_val(r_row[3], r_ch);

    always_comb begin
        unique case (r_state)
            S_T2_GO: begin
                mul_m = ACC_W'({1'b0, r_t});
                mul_b = MB_W'({1'b0, r_t});
            end
            S_T3_GO: begin
                mul_m = ACC_W'({1'b0, r_t2});
                mul_b = MB_W'({1'b0, r_t});
            end
            default: begin
                mul_m = ACC_W'(r_h[r_j]);
                unique case (r_j)
                    2'd0:    mul_b = y0 <<< 1;
                    2'd1:    mul_b = y1 - yp;
                    2'd2:    mul_b = y1 <<< 1;
                    default: mul_b = y2 - y0;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        div_start     = 1'b0;
        mul_cmd.start = 1'b0;
        mul_cmd.clear = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && t_op'(i_operation) == OP_TICK && r_playing) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (r_seg > last_seg) ? S_OUT : S_DUR;
            end
            S_DUR: begin
                n_state = S_ADV;
            end
            S_ADV: begin
                n_state = (adv && seg_p1 > last_seg) ? S_OUT : S_READ;
            end
            S_READ: begin
                if (r_rdk == 3'd4) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                if (r_row[1].dur == '0) begin
                    n_state = S_T2_GO;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_T2_GO;
                end
            end
            S_T2_GO: begin
                mul_cmd.start = 1'b1;
                mul_cmd.clear = 1'b1;
                n_state       = S_T2_WAIT;
            end
            S_T2_WAIT: begin
                if (mul_done) begin
                    n_state = S_T3_GO;
                end
            end
            S_T3_GO: begin
                mul_cmd.start = 1'b1;
                mul_cmd.clear = 1'b1;
                n_state       = S_T3_WAIT;
            end
            S_T3_WAIT: begin
                if (mul_done) begin
                    n_state = S_HERM;
                end
            end
            S_HERM: begin
                n_state = S_CH_GO;
            end
            S_CH_GO: begin
                mul_cmd.start = 1'b1;
                mul_cmd.clear = r_j == 2'd0;
                n_state       = S_CH_WAIT;
            end
            S_CH_WAIT: begin
                if (mul_done) begin
                    n_state = (r_j == 2'd3 && r_ch == 3'd6) ? S_OUT : S_CH_GO;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 9'd2;
            r_play_speed <= 16'd256;
            r_seg        <= '0;
            r_time       <= '0;
            r_started    <= 1'b0;
            r_playing    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rdk        <= '0;
            r_ch         <= '0;
            r_j          <= '0;
        end else begin
            if (cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data[8:0];
                    CFG_PLAY_SPEED: r_play_speed <= i_cfg_data;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && t_op'(i_operation) == OP_RESTART) begin
                        r_seg     <= '0;
                        r_time    <= '0;
                        r_started <= 1'b0;
                        r_playing <= 1'b1;
                    end
                end
                S_CHECK: begin
                    if (r_seg > last_seg) begin
                        r_playing <= 1'b0;
                    end else if (r_started) begin
                        r_time <= ({1'b0, r_time} + {1'b0, r_elapsed} > 33'hFFFF_FFFF)
                                  ? 32'hFFFF_FFFF : r_time + r_elapsed;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                S_ADV: begin
                    r_rdk <= '0;
                    if (adv) begin
                        r_seg <= seg_p1;
                        if (seg_p1 > last_seg) begin
                            r_playing <= 1'b0;
                        end else begin
                            r_time <= '0;
                        end
                    end
                end
                S_READ: begin
                    r_rdk <= r_rdk + 1'b1;
                end
                S_HERM: begin
                    r_ch <= '0;
                    r_j  <= '0;
                end
                S_CH_WAIT: begin
                    if (mul_done) begin
                        r_j <= r_j + 1'b1;
                        if (r_j == 2'd3) begin
                            r_ch <= r_ch + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_elapsed <= i_elapsed;
        end
        if (r_state == S_DUR) begin
            r_thresh <= rd_node.dur * r_play_speed;
        end
        if (r_state == S_READ && r_rdk != 3'd0) begin
            r_row[r_rdk[1:0] - 2'd1] <= rd_node;
        end
        if (r_state == S_DIV_GO) begin
            r_t <= '0;
        end
        if (r_state == S_DIV_WAIT && div_done) begin
            r_t <= (|div_quo[NUM_W-1:T_W]) ? '1 : div_quo[T_W-1:0];
        end
        if (r_state == S_T2_WAIT && mul_done) begin
            r_t2 <= mul_acc[T2_W+15:16];
        end
        if (r_state == S_T3_WAIT && mul_done) begin
            r_t3 <= mul_acc[T3_W+15:16];
        end
        if (r_state == S_HERM) begin
            r_h[0] <= (H_W'(r_t3) <<< 1) - H_W'(r_t2) * 3 + H_W'(65536);
            r_h[1] <= H_W'(r_t3) - (H_W'(r_t2) <<< 1) + H_W'(r_t);
            r_h[2] <= H_W'(r_t2) * 3 - (H_W'(r_t3) <<< 1);
            r_h[3] <= H_W'(r_t3) - H_W'(r_t2);
        end
        if (r_state == S_CHECK || r_state == S_ADV) begin
            // Playback end gives an all-zero pose with the finished flag.
            for (int k = 0; k < 3; k++) begin
                r_res_pos[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_res_rot[k] <= '0;
            end
            r_res_fin <= 1'b1;
        end
        if (r_state == S_HERM) begin
            r_res_fin <= 1'b0;
        end
        if (r_state == S_CH_WAIT && mul_done && r_j == 2'd3) begin
            if (r_ch < 3'd3) begin
                r_res_pos[r_ch[1:0]] <= sat_pos(mul_acc);
            end else begin
                r_res_rot[2'(r_ch - 3'd3)] <= sat_rot(mul_acc);
            end
        end
        if (load_out) begin
            o_pos_x    <= r_res_pos[0];
            o_pos_y    <= r_res_pos[1];
            o_pos_z    <= r_res_pos[2];
            o_rot_x    <= r_res_rot[0];
            o_rot_y    <= r_res_rot[1];
            o_rot_z    <= r_res_rot[2];
            o_rot_w    <= r_res_rot[3];
            o_finished <= r_res_fin;
        end
    end

    assign o_valid = r_out_valid;

    crp_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx[AW-1:0]),
        .i_wdata (wr_node),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    crp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_time, 16'd0}),
        .i_den   (r_row[1].dur),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    crp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mul_cmd),
        .i_m     (mul_m),
        .i_b     (mul_b),
        .o_acc   (mul_acc),
        .o_done  (mul_done)
    );

endmodule

// File: bench/catmull_rom_path_player_checker.sv
// ----------------------------------------------------------------------------
// catmull_rom_path_player_checker: pose predictor and result comparison
// Watches the item, configuration and result channels of the path player.
// It keeps its own node table and playback state, works out the pose for each
// tick taken while playing and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module catmull_rom_path_player_checker
    import crp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_node_index,
    input  logic signed [31:0] i_node_pos_x,
    input  logic signed [31:0] i_node_pos_y,
    input  logic signed [31:0] i_node_pos_z,
    input  logic signed [15:0] i_node_rot_x,
    input  logic signed [15:0] i_node_rot_y,
    input  logic signed [15:0] i_node_rot_z,
    input  logic signed [15:0] i_node_rot_w,
    input  logic [31:0]        i_node_duration,
    input  logic [31:0]        i_elapsed,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [31:0] o_pos_x,
    input  logic signed [31:0] o_pos_y,
    input  logic signed [31:0] o_pos_z,
    input  logic signed [15:0] o_rot_x,
    input  logic signed [15:0] o_rot_y,
    input  logic signed [15:0] o_rot_z,
    input  logic signed [15:0] o_rot_w,
    input  logic               o_finished,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 fail_count,
    output int                 outstanding
);

    typedef struct {
        logic [31:0] pos [3];
        logic [15:0] rot [4];
        logic        finished;
    } t_pose;

    typedef logic signed [127:0] t_wide;

    t_node       nodes [256];
    t_pose       pose_q [$];
    int          segment;
    logic [31:0] seg_time;
    logic        started;
    logic        playing;
    logic [8:0]  count_reg;
    logic [15:0] speed_reg;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        fail_count++;
    endtask

    // Hermite blend of one channel, floor(S / 2^17) saturated to w bits.
    function automatic logic [31:0] blend(input t_wide yp, input t_wide y0,
                                          input t_wide y1, input t_wide y2,
                                          input t_wide h [4], input int w);
        t_wide s;
        t_wide top;
        t_wide bottom;
        s = 2 * h[0] * y0 + h[1] * (y1 - yp) + 2 * h[2] * y1 + h[3] * (y2 - y0);
        s = s >>> 17;
        top = (t_wide'(1) <<< (w - 1)) - 1;
        bottom = -(t_wide'(1) <<< (w - 1));
        if (s > top) s = top;
        else if (s < bottom) s = bottom;
        return s[31:0];
    endfunction

    function automatic t_pose finish_pose();
        t_pose p;
        for (int k = 0; k < 3; k++) p.pos[k] = '0;
        for (int k = 0; k < 4; k++) p.rot[k] = '0;
        p.finished = 1'b1;
        return p;
    endfunction

    // Returns 1 and the pose when the tick gives a result.
    function automatic logic predict_tick(input logic [31:0] elapsed, output t_pose p);
        int          cnt;
        int          ip;
        int          i2;
        logic [32:0] sum;
        logic [63:0] q;
        logic [63:0] tr;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [31:0] dur;
        t_wide       h [4];
        t_node       a;
        t_node       b;
        t_node       c;
        t_node       d;
        if (!playing) return 1'b0;
        cnt = count_reg < 2 ? 2 : (count_reg > 256 ? 256 : count_reg);
        if (segment > cnt - 2) begin
            playing = 1'b0;
            p = finish_pose();
            return 1'b1;
        end
        if (started) begin
            sum = {1'b0, seg_time} + {1'b0, elapsed};
            seg_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
            started = 1'b1;
        end
        dur = nodes[segment].dur;
        if (({32'd0, seg_time} << 8) >= {32'd0, dur} * {48'd0, speed_reg}) begin
            segment++;
            if (segment > cnt - 2) begin
                playing = 1'b0;
                p = finish_pose();
                return 1'b1;
            end
            seg_time = '0;
        end
        dur = nodes[segment].dur;
        if (dur == 0) begin
            tr = 0;
        end else begin
            q = ({32'd0, seg_time} << 16) / {32'd0, dur};
            tr = q > 64'hFF_FFFF ? 64'hFF_FFFF : q;
        end
        t2 = (tr * tr) >> 16;
        t3 = (t2 * tr) >> 16;
        h[0] = 2 * t_wide'(t3) - 3 * t_wide'(t2) + 65536;
        h[1] = t_wide'(t3) - 2 * t_wide'(t2) + t_wide'(tr);
        h[2] = 3 * t_wide'(t2) - 2 * t_wide'(t3);
        h[3] = t_wide'(t3) - t_wide'(t2);
        ip = segment == 0 ? 0 : segment - 1;
        i2 = segment + 2 >= cnt ? cnt - 1 : segment + 2;
        a = nodes[ip];
        b = nodes[segment];
        c = nodes[segment + 1];
        d = nodes[i2];
        p.pos[0] = blend($signed(a.pos_x), $signed(b.pos_x), $signed(c.pos_x),
                         $signed(d.pos_x), h, 32);
        p.pos[1] = blend($signed(a.pos_y), $signed(b.pos_y), $signed(c.pos_y),
                         $signed(d.pos_y), h, 32);
        p.pos[2] = blend($signed(a.pos_z), $signed(b.pos_z), $signed(c.pos_z),
                         $signed(d.pos_z), h, 32);
        p.rot[0] = 16'(blend($signed(a.rot_x), $signed(b.rot_x), $signed(c.rot_x),
                             $signed(d.rot_x), h, 16));
        p.rot[1] = 16'(blend($signed(a.rot_y), $signed(b.rot_y), $signed(c.rot_y),
                             $signed(d.rot_y), h, 16));
        p.rot[2] = 16'(blend($signed(a.rot_z), $signed(b.rot_z), $signed(c.rot_z),
                             $signed(d.rot_z), h, 16));
        p.rot[3] = 16'(blend($signed(a.rot_w), $signed(b.rot_w), $signed(c.rot_w),
                             $signed(d.rot_w), h, 16));
        p.finished = 1'b0;
        return 1'b1;
    endfunction

    initial begin
        fail_count = 0;
        outstanding = 0;
    end

    always @(posedge i_clk) begin
        t_pose p;
        t_node n;
        if (!i_rst_n) begin
            pose_q.delete();
            segment = 0;
            seg_time = '0;
            started = 1'b0;
            playing = 1'b0;
            count_reg = 9'd2;
            speed_reg = 16'd256;
        end else begin
            if (o_valid && i_ready) begin
                if (pose_q.size() == 0) begin
                    report_mismatch("unexpected result", {31'd0, o_finished}, '0);
                end else begin
                    p = pose_q.pop_front();
                    if (o_pos_x !== p.pos[0]) report_mismatch("pos_x", o_pos_x, p.pos[0]);
                    if (o_pos_y !== p.pos[1]) report_mismatch("pos_y", o_pos_y, p.pos[1]);
                    if (o_pos_z !== p.pos[2]) report_mismatch("pos_z", o_pos_z, p.pos[2]);
                    if (o_rot_x !== p.rot[0]) report_mismatch("rot_x", o_rot_x, p.rot[0]);
                    if (o_rot_y !== p.rot[1]) report_mismatch("rot_y", o_rot_y, p.rot[1]);
                    if (o_rot_z !== p.rot[2]) report_mismatch("rot_z", o_rot_z, p.rot[2]);
                    if (o_rot_w !== p.rot[3]) report_mismatch("rot_w", o_rot_w, p.rot[3]);
                    if (o_finished !== p.finished) begin
                        report_mismatch("finished", o_finished, p.finished);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (t_cfg_index'(i_cfg_index) == CFG_NODE_COUNT) count_reg = i_cfg_data[8:0];
                else speed_reg = i_cfg_data;
            end
            if (i_valid && o_ready) begin
                case (t_op'(i_operation))
                    OP_WRITE: begin
                        n.pos_x = i_node_pos_x;
                        n.pos_y = i_node_pos_y;
                        n.pos_z = i_node_pos_z;
                        n.rot_x = i_node_rot_x;
                        n.rot_y = i_node_rot_y;
                        n.rot_z = i_node_rot_z;
                        n.rot_w = i_node_rot_w;
                        n.dur = i_node_duration;
                        nodes[i_node_index] = n;
                    end
                    OP_RESTART: begin
                        segment = 0;
                        seg_time = '0;
                        started = 1'b0;
                        playing = 1'b1;
                    end
                    OP_TICK: begin
                        if (predict_tick(i_elapsed, p)) pose_q.insert(pose_q.size(), p);
                    end
                    default: ;
                endcase
            end
        end
        outstanding = pose_q.size();
    end

endmodule

// File: bench/catmull_rom_path_player_tb.sv
// ----------------------------------------------------------------------------
// catmull_rom_path_player_tb: regression of the keyframe path player
// Drives node writes, restarts, ticks and ignored codes with random idling on
// both sides, changes node count and speed between phases, and leaves all
// checking to the checker module beside the block.
// ----------------------------------------------------------------------------
module catmull_rom_path_player_tb;
    import crp_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_operation;
    logic [7:0]         i_node_index;
    logic signed [31:0] i_node_pos_x;
    logic signed [31:0] i_node_pos_y;
    logic signed [31:0] i_node_pos_z;
    logic signed [15:0] i_node_rot_x;
    logic signed [15:0] i_node_rot_y;
    logic signed [15:0] i_node_rot_z;
    logic signed [15:0] i_node_rot_w;
    logic [31:0]        i_node_duration;
    logic [31:0]        i_elapsed;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_pos_z;
    logic signed [15:0] o_rot_x;
    logic signed [15:0] o_rot_y;
    logic signed [15:0] o_rot_z;
    logic signed [15:0] o_rot_w;
    logic               o_finished;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    int                 fail_count;
    int                 outstanding;

    logic               written [256];
    int                 items_sent;
    logic               calm;
    int                 hold_req;
    int                 hold_done;
    logic [8:0]         count_now;

    catmull_rom_path_player dut (.*);
    catmull_rom_path_player_checker checker_i (.*);

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #200_000_000;
        $display("catmull_rom_path_player regression: fail");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        i_ready = 1'b0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                i_ready = 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_done++;
            end else if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    function automatic int live_nodes(input logic [8:0] c);
        return c < 2 ? 2 : (c > 256 ? 256 : c);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_half();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 9))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(1, 32'hFFFF_FFFF);
            4, 5: return $urandom_range(1, 32'h4000);
            default: return $urandom_range(1, 32'h4_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0, 1: return 32'd0;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom;
            5, 6: return $urandom_range(0, 32'h400);
            default: return $urandom_range(0, 32'h2_0000);
        endcase
    endfunction

    task automatic send_item(input t_op op, input logic [7:0] idx,
                             input logic [31:0] dur, input logic [31:0] elapsed);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_operation = op;
        i_node_index = idx;
        i_node_pos_x = pick_word();
        i_node_pos_y = pick_word();
        i_node_pos_z = pick_word();
        i_node_rot_x = pick_half();
        i_node_rot_y = pick_half();
        i_node_rot_z = pick_half();
        i_node_rot_w = pick_half();
        i_node_duration = dur;
        i_elapsed = elapsed;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (op == OP_WRITE) written[idx] = 1'b1;
        items_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk); while (outstanding != 0);
        repeat (1200) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == CFG_NODE_COUNT) count_now = data[8:0];
    endtask

    // Every slot that playback can read is loaded before it is needed.
    task automatic load_missing();
        for (int i = 0; i < live_nodes(count_now); i++) begin
            if (!written[i]) send_item(OP_WRITE, i[7:0], pick_duration(), '0);
        end
    endtask

    task automatic run_phase(input int n_items);
        int r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) send_item(OP_WRITE, 8'($urandom), pick_duration(), $urandom);
            else if (r < 19) send_item(OP_RESTART, 8'($urandom), $urandom, $urandom);
            else if (r < 96) send_item(OP_TICK, 8'($urandom), $urandom, pick_elapsed());
            else send_item(OP_NONE, 8'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_NONE;
        i_node_index = '0;
        i_node_pos_x = '0;
        i_node_pos_y = '0;
        i_node_pos_z = '0;
        i_node_rot_x = '0;
        i_node_rot_y = '0;
        i_node_rot_z = '0;
        i_node_rot_w = '0;
        i_node_duration = '0;
        i_elapsed = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_NODE_COUNT;
        i_cfg_data = '0;
        items_sent = 0;
        calm = 1'b0;
        hold_req = 0;
        count_now = 9'd2;
        for (int i = 0; i < 256; i++) written[i] = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: four nodes, stopped ticks, ignored code, saturating time.
        write_reg(CFG_NODE_COUNT, 16'd4);
        write_reg(CFG_PLAY_SPEED, 16'd256);
        send_item(OP_WRITE, 8'd0, 32'h1_0000, '0);
        send_item(OP_WRITE, 8'd1, 32'd1, '0);
        send_item(OP_WRITE, 8'd2, 32'hFFFF_FFFF, '0);
        send_item(OP_WRITE, 8'd3, 32'h8000, '0);
        send_item(OP_WRITE, 8'd255, 32'h1234, '0);
        send_item(OP_NONE, 8'd0, '0, '0);
        send_item(OP_TICK, 8'd0, '0, 32'h100);
        send_item(OP_RESTART, 8'd0, '0, '0);
        send_item(OP_TICK, 8'd0, '0, 32'hFFFF_FFFF);
        send_item(OP_TICK, 8'd0, '0, 32'h8000);
        send_item(OP_TICK, 8'd0, '0, 32'h1_0000);
        send_item(OP_TICK, 8'd0, '0, 32'd0);
        send_item(OP_TICK, 8'd0, '0, 32'hFFFF_FFFF);
        send_item(OP_TICK, 8'd0, '0, 32'hFFFF_FFFF);
        send_item(OP_TICK, 8'd0, '0, 32'h10);
        wait_idle();
        // Shrinking the count under a running segment ends playback at once.
        write_reg(CFG_NODE_COUNT, 16'd4);
        send_item(OP_RESTART, 8'd0, '0, '0);
        send_item(OP_TICK, 8'd0, '0, '0);
        send_item(OP_TICK, 8'd0, '0, 32'h2_0000);
        send_item(OP_TICK, 8'd0, '0, 32'h2);
        wait_idle();
        write_reg(CFG_NODE_COUNT, 16'd0);
        send_item(OP_TICK, 8'd0, '0, 32'h1);
        wait_idle();

        // Long hold-off on the result side while ticks keep coming.
        write_reg(CFG_NODE_COUNT, 16'd1);
        write_reg(CFG_PLAY_SPEED, 16'hFFFF);
        send_item(OP_RESTART, 8'd0, '0, '0);
        hold_req++;
        repeat (4) send_item(OP_TICK, 8'd0, '0, 32'h40);

        while (items_sent < 640) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: write_reg(CFG_NODE_COUNT, 16'($urandom_range(0, 3)));
                1: write_reg(CFG_NODE_COUNT, 16'($urandom_range(4, 40)));
                default: write_reg(CFG_NODE_COUNT, 16'($urandom_range(2, 8)));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(CFG_PLAY_SPEED, 16'd0);
                1: write_reg(CFG_PLAY_SPEED, 16'hFFFF);
                2: write_reg(CFG_PLAY_SPEED, 16'($urandom));
                default: write_reg(CFG_PLAY_SPEED, 16'($urandom_range(64, 512)));
            endcase
            load_missing();
            send_item(OP_RESTART, 8'($urandom), $urandom, $urandom);
            run_phase(60);
        end

        // Full table, then a last stretch with no idling.
        wait_idle();
        write_reg(CFG_NODE_COUNT, 16'd511);
        write_reg(CFG_PLAY_SPEED, 16'd0);
        load_missing();
        calm = 1'b1;
        send_item(OP_RESTART, 8'd0, '0, '0);
        run_phase(30);
        wait_idle();
        write_reg(CFG_NODE_COUNT, 16'd256);
        write_reg(CFG_PLAY_SPEED, 16'd256);
        send_item(OP_RESTART, 8'd0, '0, '0);
        run_phase(30);

        wait_idle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("catmull_rom_path_player regression: pass");
        end else begin
            $display("catmull_rom_path_player regression: fail");
        end
        $finish;
    end

endmodule
